### rtl/core/c_lex_pkg.sv
// shared types, constants and character functions for the c subset lexer
`default_nettype none

package c_lex_pkg;

    localparam int POS_BITS   = 16;
    localparam int VALUE_BITS = 32;
    localparam int POS_W      = 16;
    localparam int LEN_W      = 16;
    localparam int NUM_W      = 32;
    localparam int KW_COUNT   = 6;

    localparam logic [2:0] KIND_NUM     = 3'd0;
    localparam logic [2:0] KIND_IDENT   = 3'd1;
    localparam logic [2:0] KIND_KEYWORD = 3'd2;
    localparam logic [2:0] KIND_PUNCT   = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;
    localparam logic [2:0] KIND_ERROR   = 3'd5;

    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_BANG = 8'h21;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // return, if, else, for, while, int padded with zero
    localparam logic [7:0] KW_CHAR [KW_COUNT][8] = '{
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
        16'd6, 16'd2, 16'd4, 16'd3, 16'd5, 16'd3
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in_req;

    typedef struct packed {
        logic [2:0]       token_kind;
        logic [POS_W-1:0] start_pos;
        logic [LEN_W-1:0] token_len;
        logic [NUM_W-1:0] num_value;
        logic [2:0]       keyword_id;
        logic [7:0]       punct_first;
        logic [7:0]       punct_second;
        logic             last_of_run;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       d0;
        t_tok       d1;
    } t_push;

    typedef struct packed {
        logic       hit;
        logic [2:0] id;
    } t_kw;

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_first(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]};
    endfunction

    // keywords that still match after character c at offset len
    function automatic logic [KW_COUNT-1:0] kw_keep(input logic [LEN_W-1:0] len,
                                                     input logic [7:0] c);
        logic [KW_COUNT-1:0] keep;
        for (int k = 0; k < KW_COUNT; k++) begin
            keep[k] = (len < KW_LEN[k]) && (KW_CHAR[k][len[2:0]] == c);
        end
        return keep;
    endfunction

    function automatic t_kw kw_find(input logic [KW_COUNT-1:0] alive,
                                    input logic [LEN_W-1:0] len);
        t_kw r;
        r = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (alive[k] && len == KW_LEN[k]) begin
                r.hit = 1'b1;
                r.id  = 3'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/c_lex_if.sv
// valid/ready channels for source bytes and tokens
`default_nettype none

interface c_lex_in_if;
    import c_lex_pkg::*;
    logic    valid;
    logic    ready;
    t_in_req req;
    modport source (output valid, output req, input ready);
    modport sink (input valid, input req, output ready);
endinterface

interface c_lex_tok_if;
    import c_lex_pkg::*;
    logic valid;
    logic ready;
    t_tok tok;
    modport source (output valid, output tok, input ready);
    modport sink (input valid, input tok, output ready);
endinterface

`default_nettype wire

### rtl/core/c_lex_fifo.sv
// four entry token queue, up to two writes and one read per cycle
`default_nettype none

module c_lex_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire c_lex_pkg::t_push i_push,
    output logic                 o_room,
    c_lex_tok_if.source          o_tok
);
    import c_lex_pkg::*;

    t_tok       r_mem [4];
    logic [1:0] r_wp, r_rp, n_wp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign pop         = o_tok.valid && o_tok.ready;
    assign o_tok.valid = (r_cnt != 3'd0);
    assign o_tok.tok   = r_mem[r_rp];
    assign o_room      = (r_cnt <= 3'd2);

    always_comb begin
        n_wp  = r_wp + i_push.cnt;
        n_rp  = r_rp + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, i_push.cnt} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.d0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_push.d1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/c_subset_lexer.sv
// streaming lexer for a small c subset: one source byte per request in, tokens out
// each byte passes the input register, then its tokens go into the token queue
// throughput: one byte per cycle while the queue has room; a byte that yields two
//   tokens writes both; the queue's single read port offers them one at a time
// reset: synchronous active low, returns the scanner to idle at offset zero
// end of text flushes the pending token, emits an end token and rewinds state
`default_nettype none

module c_subset_lexer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    c_lex_in_if.sink   i_src,
    c_lex_tok_if.source o_tok
);
    import c_lex_pkg::*;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_NUM   = 5'b00010,
        MODE_IDENT = 5'b00100,
        MODE_PUNCT = 5'b01000,
        MODE_ERROR = 5'b10000
    } t_mode;

    logic                  r_in_vld;
    t_in_req               r_in;
    logic                  fire, room;

    t_mode                 r_mode, n_mode;
    logic [POS_BITS-1:0]   r_start, n_start, r_pos, n_pos, pos_inc;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [KW_COUNT-1:0]   r_alive, n_alive;
    logic [7:0]            r_pend, n_pend;
    logic [LEN_W-1:0]      r_len, n_len, len_inc;

    logic [VALUE_BITS+3:0] acc_ext, acc_mul;
    logic [7:0]            c, digit;
    t_kw                   kw;
    t_tok                  fl_tok, tok_a, tok_b;
    logic                  fl_has, cont;
    logic [1:0]            cnt;
    t_push                 push;

    assign fire        = r_in_vld && room;
    assign i_src.ready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_src.ready) begin
            r_in_vld <= i_src.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_src.ready && i_src.valid) begin
            r_in <= i_src.req;
        end
    end

    assign c       = r_in.ch;
    assign digit   = c - CH_ZERO;
    assign pos_inc = r_pos + 1'b1;
    assign len_inc = (r_len == '1) ? r_len : r_len + 1'b1;
    assign acc_ext = {4'b0000, r_acc};
    assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + (VALUE_BITS + 4)'(digit[3:0]);
    assign kw      = kw_find(r_alive, r_len);

    // pending token as it stands before this byte
    always_comb begin
        fl_tok           = '0;
        fl_tok.start_pos = POS_W'(r_start);
        fl_tok.token_len = r_len;
        fl_has           = 1'b0;
        case (r_mode)
            MODE_NUM: begin
                fl_has           = 1'b1;
                fl_tok.token_kind = KIND_NUM;
                fl_tok.num_value = NUM_W'(r_acc);
            end
            MODE_IDENT: begin
                fl_has            = 1'b1;
                fl_tok.token_kind = kw.hit ? KIND_KEYWORD : KIND_IDENT;
                fl_tok.keyword_id = kw.hit ? kw.id : 3'd0;
            end
            MODE_PUNCT: begin
                fl_has            = 1'b1;
                fl_tok.token_kind = KIND_PUNCT;
                fl_tok.token_len  = LEN_W'(1);
                fl_tok.punct_first = r_pend;
            end
            default: begin
                fl_has = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_pos   = r_pos;
        n_acc   = r_acc;
        n_alive = r_alive;
        n_pend  = r_pend;
        n_len   = r_len;
        tok_a   = '0;
        tok_b   = '0;
        cnt     = 2'd0;
        cont    = 1'b0;
        if (r_in.end_of_text) begin
            tok_b.token_kind = KIND_END;
            tok_b.start_pos  = POS_W'(r_pos);
            if (r_mode != MODE_ERROR && fl_has) begin
                tok_a = fl_tok;
                cnt   = 2'd2;
            end else begin
                tok_a = tok_b;
                cnt   = 2'd1;
            end
            n_mode  = MODE_IDLE;
            n_start = '0;
            n_pos   = '0;
            n_acc   = '0;
            n_alive = '1;
            n_pend  = '0;
            n_len   = '0;
        end else if (r_mode == MODE_ERROR) begin
            n_pos = pos_inc;
        end else begin
            n_pos = pos_inc;
            if (r_mode == MODE_NUM && is_digit(c)) begin
                cont  = 1'b1;
                n_len = len_inc;
                n_acc = (acc_mul[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? '1
                                                                   : acc_mul[VALUE_BITS-1:0];
            end else if (r_mode == MODE_IDENT && (is_first(c) || is_digit(c))) begin
                cont    = 1'b1;
                n_len   = len_inc;
                n_alive = r_alive & kw_keep(r_len, c);
            end else if (r_mode == MODE_PUNCT && c == CH_EQ) begin
                cont               = 1'b1;
                tok_a              = fl_tok;
                tok_a.token_len    = LEN_W'(2);
                tok_a.punct_second = c;
                cnt                = 2'd1;
                n_mode             = MODE_IDLE;
            end
            if (!cont) begin
                // close the pending token, then start on this byte
                if (fl_has) begin
                    tok_a = fl_tok;
                    cnt   = 2'd1;
                end
                n_mode = MODE_IDLE;
                tok_b  = '0;
                tok_b.start_pos = POS_W'(r_pos);
                tok_b.token_len = LEN_W'(1);
                if (is_space(c)) begin
                    n_mode = MODE_IDLE;
                end else if (is_digit(c)) begin
                    n_mode  = MODE_NUM;
                    n_start = r_pos;
                    n_acc   = VALUE_BITS'(digit[3:0]);
                    n_len   = LEN_W'(1);
                end else if (is_first(c)) begin
                    n_mode  = MODE_IDENT;
                    n_start = r_pos;
                    n_alive = kw_keep('0, c);
                    n_len   = LEN_W'(1);
                end else if (is_punct(c)) begin
                    if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
                        n_mode  = MODE_PUNCT;
                        n_start = r_pos;
                        n_pend  = c;
                    end else begin
                        tok_b.token_kind  = KIND_PUNCT;
                        tok_b.punct_first = c;
                        if (fl_has) begin
                            cnt = 2'd2;
                        end else begin
                            tok_a = tok_b;
                            cnt   = 2'd1;
                        end
                    end
                end else begin
                    tok_b.token_kind = KIND_ERROR;
                    n_mode           = MODE_ERROR;
                    if (fl_has) begin
                        cnt = 2'd2;
                    end else begin
                        tok_a = tok_b;
                        cnt   = 2'd1;
                    end
                end
            end
        end
        tok_a.last_of_run = (cnt == 2'd1);
        tok_b.last_of_run = 1'b1;
    end

    always_comb begin
        push.cnt = fire ? cnt : 2'd0;
        push.d0  = tok_a;
        push.d1  = tok_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_acc   <= '0;
            r_alive <= '1;
            r_pend  <= '0;
            r_len   <= '0;
        end else if (fire) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_acc   <= n_acc;
            r_alive <= n_alive;
            r_pend  <= n_pend;
            r_len   <= n_len;
        end
    end

    c_lex_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_tok   (o_tok)
    );

endmodule

`default_nettype wire

### test/c_subset_lexer_tb.sv
// self-checking testbench for c_subset_lexer against a token predictor
module c_subset_lexer_tb;
    import c_lex_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_BYTES = 1450;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CALM_FROM = 600;
    localparam int CALM_TO = 900;

    typedef enum logic [2:0] {SCAN_IDLE, SCAN_NUM, SCAN_IDENT, SCAN_PUNCT, SCAN_ERROR} t_scan;

    logic clk = 1'b0;
    logic rst_n;

    c_lex_in_if  src_if ();
    c_lex_tok_if tok_if ();

    c_subset_lexer u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_src   (src_if),
        .o_tok   (tok_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    t_in_req src_bytes [$];
    t_tok    tokens_due [$];
    int      reqs_taken = 0;
    int      mismatches = 0;
    int      cycles = 0;
    int      hold_left = 0;
    logic    hold_done = 1'b0;

    // lexer state as the predictor sees it
    t_scan       scan;
    logic [15:0] lex_pos;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [31:0] num_acc;
    logic [5:0]  kw_alive;
    logic [7:0]  held_punct;
    t_tok        step_buf [2];
    int          step_toks;

    function automatic string kw_word(int k);
        case (k)
            0: return "return";
            1: return "if";
            2: return "else";
            3: return "for";
            4: return "while";
            default: return "int";
        endcase
    endfunction

    function automatic logic ch_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic ch_word(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic ch_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic ch_punct(logic [7:0] c);
        return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    function automatic void lex_reset();
        scan = SCAN_IDLE;
        lex_pos = '0;
        tok_start = '0;
        tok_len = '0;
        num_acc = '0;
        kw_alive = '1;
        held_punct = '0;
    endfunction

    function automatic void add_tok(logic [2:0] kind, logic [15:0] start, logic [15:0] len,
                                    logic [31:0] val, logic [2:0] kw, logic [7:0] p1,
                                    logic [7:0] p2);
        t_tok t;
        t.token_kind = kind;
        t.start_pos = start;
        t.token_len = len;
        t.num_value = val;
        t.keyword_id = kw;
        t.punct_first = p1;
        t.punct_second = p2;
        t.last_of_run = 1'b0;
        step_buf[step_toks] = t;
        step_toks++;
    endfunction

    function automatic void kw_narrow(logic [7:0] c);
        string w;
        for (int k = 0; k < 6; k++) begin
            w = kw_word(k);
            if (int'(tok_len) >= w.len() || w[int'(tok_len)] != c) kw_alive[k] = 1'b0;
        end
    endfunction

    function automatic void flush_tok();
        logic [2:0] kind;
        logic [2:0] id;
        string      w;
        case (scan)
            SCAN_NUM: add_tok(KIND_NUM, tok_start, tok_len, num_acc, 3'd0, 8'd0, 8'd0);
            SCAN_IDENT: begin
                kind = KIND_IDENT;
                id = 3'd0;
                for (int k = 0; k < 6; k++) begin
                    w = kw_word(k);
                    if (kind == KIND_IDENT && kw_alive[k] && int'(tok_len) == w.len()) begin
                        kind = KIND_KEYWORD;
                        id = 3'(k);
                    end
                end
                add_tok(kind, tok_start, tok_len, 32'd0, id, 8'd0, 8'd0);
            end
            SCAN_PUNCT: add_tok(KIND_PUNCT, tok_start, 16'd1, 32'd0, 3'd0, held_punct, 8'd0);
            default: ;
        endcase
        scan = SCAN_IDLE;
    endfunction

    function automatic void lex_step(t_in_req r);
        logic [7:0]  c;
        logic [35:0] wide;
        logic        taken;
        c = r.ch;
        step_toks = 0;
        taken = 1'b0;
        if (r.end_of_text) begin
            if (scan != SCAN_ERROR) flush_tok();
            add_tok(KIND_END, lex_pos, 16'd0, 32'd0, 3'd0, 8'd0, 8'd0);
            lex_reset();
        end else if (scan == SCAN_ERROR) begin
            lex_pos++;
        end else begin
            case (scan)
                SCAN_NUM: begin
                    if (ch_digit(c)) begin
                        wide = 36'(num_acc) * 36'd10 + 36'(c - CH_ZERO);
                        num_acc = (wide > 36'hFFFF_FFFF) ? '1 : wide[31:0];
                        if (tok_len != '1) tok_len++;
                        taken = 1'b1;
                    end else begin
                        flush_tok();
                    end
                end
                SCAN_IDENT: begin
                    if (ch_word(c) || ch_digit(c)) begin
                        kw_narrow(c);
                        if (tok_len != '1) tok_len++;
                        taken = 1'b1;
                    end else begin
                        flush_tok();
                    end
                end
                SCAN_PUNCT: begin
                    if (c == CH_EQ) begin
                        add_tok(KIND_PUNCT, tok_start, 16'd2, 32'd0, 3'd0, held_punct, c);
                        scan = SCAN_IDLE;
                        taken = 1'b1;
                    end else begin
                        flush_tok();
                    end
                end
                default: ;
            endcase
            if (!taken) begin
                if (ch_blank(c)) begin
                end else if (ch_digit(c)) begin
                    scan = SCAN_NUM;
                    tok_start = lex_pos;
                    num_acc = 32'(c - CH_ZERO);
                    tok_len = 16'd1;
                end else if (ch_word(c)) begin
                    scan = SCAN_IDENT;
                    tok_start = lex_pos;
                    kw_alive = '1;
                    tok_len = 16'd0;
                    kw_narrow(c);
                    tok_len = 16'd1;
                end else if (ch_punct(c)) begin
                    if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
                        scan = SCAN_PUNCT;
                        tok_start = lex_pos;
                        held_punct = c;
                    end else begin
                        add_tok(KIND_PUNCT, lex_pos, 16'd1, 32'd0, 3'd0, c, 8'd0);
                    end
                end else begin
                    add_tok(KIND_ERROR, lex_pos, 16'd1, 32'd0, 3'd0, 8'd0, 8'd0);
                    scan = SCAN_ERROR;
                end
            end
            lex_pos++;
        end
        for (int i = 0; i < step_toks; i++) begin
            step_buf[i].last_of_run = (i == step_toks - 1);
            tokens_due.push_back(step_buf[i]);
        end
    endfunction

    // source text generation
    function automatic void put_ch(logic [7:0] c);
        t_in_req r;
        r.ch = c;
        r.end_of_text = 1'b0;
        src_bytes.push_back(r);
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) put_ch(s[i]);
    endfunction

    function automatic void put_eot();
        t_in_req r;
        r.ch = 8'($urandom_range(255));
        r.end_of_text = 1'b1;
        src_bytes.push_back(r);
    endfunction

    function automatic logic [7:0] rand_blank();
        int b;
        b = $urandom_range(5);
        return (b == 5) ? 8'h20 : 8'(8'h09 + b);
    endfunction

    function automatic logic [7:0] rand_punct();
        case ($urandom_range(3))
            0: return 8'($urandom_range(8'h2F, 8'h21));
            1: return 8'($urandom_range(8'h40, 8'h3A));
            2: return 8'($urandom_range(8'h60, 8'h5B));
            default: return 8'($urandom_range(8'h7E, 8'h7B));
        endcase
    endfunction

    function automatic logic [7:0] rand_word_ch(logic first);
        int k;
        k = $urandom_range(first ? 52 : 62);
        if (k < 26) return 8'("a" + k);
        if (k < 52) return 8'("A" + k - 26);
        if (k == 52) return "_";
        return 8'("0" + k - 53);
    endfunction

    function automatic void gen_text();
        int    ntok;
        int    pick;
        int    n;
        string w;
        ntok = $urandom_range(15, 3);
        for (int t = 0; t < ntok; t++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                w = kw_word($urandom_range(5));
                case ($urandom_range(5))
                    0: w = w.substr(0, w.len() - 2);
                    1: w = {w, "s"};
                    default: ;
                endcase
                put_str(w);
            end else if (pick < 30) begin
                n = $urandom_range(8, 1);
                for (int i = 0; i < n; i++) put_ch(rand_word_ch(i == 0));
            end else if (pick < 50) begin
                n = ($urandom_range(9) == 0) ? $urandom_range(14, 9) : $urandom_range(4, 1);
                for (int i = 0; i < n; i++) put_ch(8'("0" + $urandom_range(9)));
            end else if (pick < 52) begin
                if ($urandom_range(1) != 0) put_str("4294967295");
                else put_str("4294967296");
            end else if (pick < 72) begin
                case ($urandom_range(7))
                    0: put_str("==");
                    1: put_str("!=");
                    2: put_str("<=");
                    3: put_str(">=");
                    4: put_str("=");
                    5: put_str("!");
                    6: put_str("<");
                    default: put_str(">");
                endcase
            end else if (pick < 90) begin
                put_ch(rand_punct());
            end else if (pick < 95) begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) put_ch(rand_blank());
            end else begin
                put_ch(8'($urandom_range(255)));
            end
            if ($urandom_range(2) != 0) put_ch(rand_blank());
        end
        put_eot();
    endfunction

    function automatic string tok_str(t_tok t);
        return $sformatf("kind %0d start %0d len %0d value %0d kw %0d punct %02h %02h last %0b",
                         t.token_kind, t.start_pos, t.token_len, t.num_value, t.keyword_id,
                         t.punct_first, t.punct_second, t.last_of_run);
    endfunction

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            src_if.valid <= 1'b0;
        end else begin
            if (src_if.valid && src_if.ready) begin
                lex_step(src_if.req);
                reqs_taken++;
            end
            if (!src_if.valid || src_if.ready) begin
                if (src_bytes.size() > 0 &&
                    ((reqs_taken >= CALM_FROM && reqs_taken < CALM_TO) ||
                     $urandom_range(99) >= 38)) begin
                    src_if.req <= src_bytes.pop_front();
                    src_if.valid <= 1'b1;
                end else begin
                    src_if.valid <= 1'b0;
                end
            end
        end
    end

    // token monitor and receiver stalls
    always @(posedge clk) begin
        if (!rst_n) begin
            tok_if.ready <= 1'b0;
        end else begin
            if (tok_if.valid && tok_if.ready) begin
                if (tokens_due.size() == 0) begin
                    flag_mismatch({"unexpected token ", tok_str(tok_if.tok)});
                end else if (tok_if.tok !== tokens_due[0]) begin
                    flag_mismatch({"expected ", tok_str(tokens_due[0]),
                                   " got ", tok_str(tok_if.tok)});
                    void'(tokens_due.pop_front());
                end else begin
                    void'(tokens_due.pop_front());
                end
            end
            if (!hold_done && reqs_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                tok_if.ready <= 1'b0;
            end else if (reqs_taken >= CALM_FROM && reqs_taken < CALM_TO) begin
                tok_if.ready <= 1'b1;
            end else begin
                tok_if.ready <= ($urandom_range(99) >= 38);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        src_if.valid = 1'b0;
        src_if.req = '0;
        tok_if.ready = 1'b0;
        lex_reset();

        // keyword, identifier, two-char operators, number, single punctuator
        put_str("if x_1>=42!=b;");
        put_eot();
        // pending operator flushed by another operator
        put_str("<<=");
        put_eot();
        // illegal byte after a pending token, then ignored bytes
        put_ch("a");
        put_ch(8'hFF);
        put_ch("b");
        put_eot();
        put_ch(8'h00);
        put_eot();

        while (src_bytes.size() < RANDOM_BYTES) gen_text();

        // value saturation on a long digit run, then a trailing keyword
        put_str(" x ");
        repeat (12) put_ch("7");
        put_str(" if");
        put_eot();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (src_bytes.size() != 0 || src_if.valid || tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tokens_due.size() != 0)
            flag_mismatch($sformatf("%0d tokens never arrived", tokens_due.size()));
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
